// ----- rtl/core/tlbpt_pkg.sv -----
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int FRAME_COUNT = 128;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W  = 16;
    localparam int PHYS_W  = 15;
    localparam int COUNT_W = 32;

    localparam int PAGE_W    = ADDR_W - OFFSET_BITS;
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PA_FULL_W = (FRAME_W + OFFSET_BITS > PHYS_W) ? FRAME_W + OFFSET_BITS
                                                                 : PHYS_W;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [PAGE_W-1:0]      page_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [FRAME_W-1:0]     frame_t;
    typedef logic [TLB_IDX_W-1:0]   tlb_idx_t;
    typedef logic [PHYS_W-1:0]      phys_t;
    typedef logic [COUNT_W-1:0]     count_t;

    localparam frame_t   FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
    localparam tlb_idx_t TLB_LAST   = TLB_IDX_W'(TLB_ENTRIES - 1);
    localparam count_t   COUNT_MAX  = '1;

    // frame above the offset, cut to the physical address field
    function automatic phys_t phys_addr(frame_t frame, offset_t offset);
        logic [PA_FULL_W-1:0] wide;
        wide = (PA_FULL_W'(frame) << OFFSET_BITS) | PA_FULL_W'(offset);
        return wide[PHYS_W-1:0];
    endfunction

    function automatic count_t bump(count_t c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ----- rtl/core/tlbpt_ram.sv -----
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/tlb_page_translator.sv -----
// channel  | direction | handshake          | payload
// in       | into      | in_valid/in_stall  | vaddr
// out      | out of    | out_valid/out_stall| paddr, tlb_hit, page_fault,
//          |           |                    | hit_total, fault_total
//
// TLB hit: S_TLB goes straight to S_DONE. TLB miss: the frame table RAM is walked one
// entry per cycle from frame 0, stopping at the owner, at the first unused frame or at the
// last frame, then S_FILL updates the TLB (and the table on a fault) before S_DONE.
// Reset clears TLB valid bits, pointers and counters; frame table use is tracked by a
// fill count, so no clearing pass is needed. One beat is in work at a time; the next
// beat is taken once a result is loaded, even while out_stall holds it.
module tlb_page_translator (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  tlbpt_pkg::addr_t       vaddr,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tlbpt_pkg::phys_t       paddr,
    output logic                   tlb_hit,
    output logic                   page_fault,
    output tlbpt_pkg::count_t      hit_total,
    output tlbpt_pkg::count_t      fault_total
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TLB  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]            state_reg, state_next;
    tlbpt_pkg::addr_t      addr_reg, addr_next;
    tlbpt_pkg::frame_t     frame_reg, frame_next;
    logic                  hit_reg, hit_next;
    logic                  fault_reg, fault_next;

    logic                  tlb_valid_reg [0:tlbpt_pkg::TLB_ENTRIES-1];
    logic                  tlb_valid_next [0:tlbpt_pkg::TLB_ENTRIES-1];
    tlbpt_pkg::page_t      tlb_page_reg [0:tlbpt_pkg::TLB_ENTRIES-1];
    tlbpt_pkg::page_t      tlb_page_next [0:tlbpt_pkg::TLB_ENTRIES-1];
    tlbpt_pkg::frame_t     tlb_frame_reg [0:tlbpt_pkg::TLB_ENTRIES-1];
    tlbpt_pkg::frame_t     tlb_frame_next [0:tlbpt_pkg::TLB_ENTRIES-1];
    tlbpt_pkg::tlb_idx_t   fill_ptr_reg, fill_ptr_next;

    tlbpt_pkg::frame_t     next_free_reg, next_free_next;
    logic                  frames_full_reg, frames_full_next;

    tlbpt_pkg::frame_t     walk_idx_reg, walk_idx_next;
    logic                  issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    tlbpt_pkg::frame_t     data_idx_reg, data_idx_next;

    tlbpt_pkg::count_t     hit_cnt_reg, hit_cnt_next;
    tlbpt_pkg::count_t     fault_cnt_reg, fault_cnt_next;

    logic                  out_valid_reg, out_valid_next;
    tlbpt_pkg::phys_t      out_phys_reg, out_phys_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_fault_reg, out_fault_next;

    logic                  ram_we;
    tlbpt_pkg::page_t      ram_rdata;

    tlbpt_pkg::page_t      page;
    tlbpt_pkg::offset_t    offset;
    logic                  tlb_match;
    tlbpt_pkg::frame_t     tlb_match_frame;
    logic                  owner_valid;

    assign page   = addr_reg[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_BITS];
    assign offset = addr_reg[tlbpt_pkg::OFFSET_BITS-1:0];

    // frames are handed out in order, so the used ones are a prefix until the table fills
    assign owner_valid = frames_full_reg || (data_idx_reg < next_free_reg);

    tlbpt_ram #(
        .WIDTH (tlbpt_pkg::PAGE_W),
        .DEPTH (tlbpt_pkg::FRAME_COUNT)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (frame_reg),
        .wr_data (page),
        .rd_addr (walk_idx_reg),
        .rd_data (ram_rdata)
    );

    // lowest matching entry wins
    always_comb
    begin
        tlb_match       = 1'b0;
        tlb_match_frame = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page))
            begin
                tlb_match       = 1'b1;
                tlb_match_frame = tlb_frame_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        frame_next       = frame_reg;
        hit_next         = hit_reg;
        fault_next       = fault_reg;
        tlb_valid_next   = tlb_valid_reg;
        tlb_page_next    = tlb_page_reg;
        tlb_frame_next   = tlb_frame_reg;
        fill_ptr_next    = fill_ptr_reg;
        next_free_next   = next_free_reg;
        frames_full_next = frames_full_reg;
        walk_idx_next    = walk_idx_reg;
        issue_next       = issue_reg;
        pend_next        = pend_reg;
        data_idx_next    = data_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        fault_cnt_next   = fault_cnt_reg;
        out_valid_next   = out_valid_reg;
        out_phys_next    = out_phys_reg;
        out_hit_next     = out_hit_reg;
        out_fault_next   = out_fault_reg;
        ram_we           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next  = vaddr;
                    state_next = S_TLB;
                end
            end
            S_TLB:
            begin
                fault_next = 1'b0;
                if (tlb_match)
                begin
                    hit_next   = 1'b1;
                    frame_next = tlb_match_frame;
                    state_next = S_DONE;
                end
                else
                begin
                    hit_next      = 1'b0;
                    walk_idx_next = '0;
                    issue_next    = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                // read address runs one ahead of the compare
                walk_idx_next = walk_idx_reg + 1'b1;
                issue_next    = issue_reg && (walk_idx_reg != tlbpt_pkg::FRAME_LAST);
                pend_next     = issue_reg;
                data_idx_next = walk_idx_reg;
                if (pend_reg)
                begin
                    if (owner_valid && (ram_rdata == page))
                    begin
                        frame_next = data_idx_reg;
                        pend_next  = 1'b0;
                        state_next = S_FILL;
                    end
                    else if (!owner_valid || (data_idx_reg == tlbpt_pkg::FRAME_LAST))
                    begin
                        frame_next = next_free_reg;
                        fault_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                if (fault_reg)
                begin
                    ram_we = 1'b1;
                    if (next_free_reg == tlbpt_pkg::FRAME_LAST)
                    begin
                        next_free_next   = '0;
                        frames_full_next = 1'b1;
                    end
                    else
                    begin
                        next_free_next = next_free_reg + 1'b1;
                    end
                    // drop stale translations to the reused frame
                    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
                    begin
                        if (tlb_frame_reg[i] == frame_reg)
                        begin
                            tlb_valid_next[i] = 1'b0;
                        end
                    end
                end
                tlb_valid_next[fill_ptr_reg] = 1'b1;
                tlb_page_next[fill_ptr_reg]  = page;
                tlb_frame_next[fill_ptr_reg] = frame_reg;
                fill_ptr_next = (fill_ptr_reg == tlbpt_pkg::TLB_LAST) ? '0
                                                                      : fill_ptr_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_phys_next  = tlbpt_pkg::phys_addr(frame_reg, offset);
                    out_hit_next   = hit_reg;
                    out_fault_next = fault_reg;
                    if (hit_reg)
                    begin
                        hit_cnt_next = tlbpt_pkg::bump(hit_cnt_reg);
                    end
                    if (fault_reg)
                    begin
                        fault_cnt_next = tlbpt_pkg::bump(fault_cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_ptr_reg    <= '0;
            next_free_reg   <= '0;
            frames_full_reg <= 1'b0;
            issue_reg       <= 1'b0;
            pend_reg        <= 1'b0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                tlb_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            fill_ptr_reg    <= fill_ptr_next;
            next_free_reg   <= next_free_next;
            frames_full_reg <= frames_full_next;
            issue_reg       <= issue_next;
            pend_reg        <= pend_next;
            hit_cnt_reg     <= hit_cnt_next;
            fault_cnt_reg   <= fault_cnt_next;
            out_valid_reg   <= out_valid_next;
            tlb_valid_reg   <= tlb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_next_dummy_guard:
        begin
            addr_reg      <= addr_next;
            frame_reg     <= frame_next;
            hit_reg       <= hit_next;
            fault_reg     <= fault_next;
            walk_idx_reg  <= walk_idx_next;
            data_idx_reg  <= data_idx_next;
            out_phys_reg  <= out_phys_next;
            out_hit_reg   <= out_hit_next;
            out_fault_reg <= out_fault_next;
            tlb_page_reg  <= tlb_page_next;
            tlb_frame_reg <= tlb_frame_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign paddr       = out_phys_reg;
    assign tlb_hit     = out_hit_reg;
    assign page_fault  = out_fault_reg;
    assign hit_total   = hit_cnt_reg;
    assign fault_total = fault_cnt_reg;

`ifndef SYNTH
    a_hit_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_fault_reg))
        else $error("result flags both hit and fault");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_TLB))
        else $error("accepted beat did not start a lookup");

    a_fault_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && fault_reg) |=> (next_free_reg != $past(next_free_reg)))
        else $error("page fault did not advance the frame pointer");

    a_hit_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TLB && tlb_match) |=> (state_reg == S_DONE && hit_reg))
        else $error("TLB hit did not go straight to the result");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import tlbpt_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 150;
    localparam int WARM_BASE       = 32;
    localparam int WARM_PAGES      = 40;
    localparam int MIX_ITEMS       = 700;
    localparam int TAIL_ITEMS      = 120;

    typedef struct packed {
        phys_t  phys;
        logic   hit;
        logic   fault;
        count_t hit_total;
        count_t fault_total;
    } translation_t;

    class translation_scoreboard;
        bit       tag_valid [TLB_ENTRIES];
        page_t    tag_page [TLB_ENTRIES];
        frame_t   tag_frame [TLB_ENTRIES];
        tlb_idx_t fill_slot;
        bit       owner_valid [FRAME_COUNT];
        page_t    owner_page [FRAME_COUNT];
        frame_t   free_frame;
        count_t   hit_count;
        count_t   fault_count;

        translation_t awaited[$];
        int errors;
        int results_seen;
        int reuses;
        int invalidations;

        function new();
            int i;
            for (i = 0; i < TLB_ENTRIES; i++)
            begin
                tag_valid[i] = 1'b0;
                tag_page[i]  = '0;
                tag_frame[i] = '0;
            end
            for (i = 0; i < FRAME_COUNT; i++)
            begin
                owner_valid[i] = 1'b0;
                owner_page[i]  = '0;
            end
            fill_slot     = '0;
            free_frame    = '0;
            hit_count     = '0;
            fault_count   = '0;
            errors        = 0;
            results_seen  = 0;
            reuses        = 0;
            invalidations = 0;
        endfunction

        function bit page_mapped(page_t p);
            int i;
            for (i = 0; i < FRAME_COUNT; i++)
                if (owner_valid[i] && owner_page[i] == p)
                    return 1'b1;
            return 1'b0;
        endfunction

        // page that loses its frame on the next fault
        function bit victim(output page_t p);
            p = owner_page[free_frame];
            return owner_valid[free_frame];
        endfunction

        function void note_address(addr_t addr);
            page_t        page;
            offset_t      offset;
            frame_t       frame;
            translation_t t;
            bit           found;
            int           i;
            page   = addr[ADDR_W-1:OFFSET_BITS];
            offset = addr[OFFSET_BITS-1:0];
            frame  = '0;
            found  = 1'b0;
            t      = '0;
            for (i = 0; i < TLB_ENTRIES; i++)
                if (!t.hit && tag_valid[i] && tag_page[i] == page)
                begin
                    t.hit = 1'b1;
                    frame = tag_frame[i];
                end
            if (t.hit)
            begin
                if (hit_count != COUNT_MAX)
                    hit_count = hit_count + 1'b1;
            end
            else
            begin
                for (i = 0; i < FRAME_COUNT; i++)
                    if (!found && owner_valid[i] && owner_page[i] == page)
                    begin
                        found = 1'b1;
                        frame = frame_t'(i);
                    end
                if (!found)
                begin
                    frame = free_frame;
                    if (owner_valid[frame])
                        reuses++;
                    free_frame = (free_frame == FRAME_LAST) ? '0 : free_frame + 1'b1;
                    owner_valid[frame] = 1'b1;
                    owner_page[frame]  = page;
                    // stale translations to the recycled frame go first
                    for (i = 0; i < TLB_ENTRIES; i++)
                        if (tag_valid[i] && tag_frame[i] == frame)
                        begin
                            tag_valid[i] = 1'b0;
                            invalidations++;
                        end
                    t.fault = 1'b1;
                    if (fault_count != COUNT_MAX)
                        fault_count = fault_count + 1'b1;
                end
                tag_valid[fill_slot] = 1'b1;
                tag_page[fill_slot]  = page;
                tag_frame[fill_slot] = frame;
                fill_slot = (fill_slot == TLB_LAST) ? '0 : fill_slot + 1'b1;
            end
            t.phys        = PHYS_W'((longint'(frame) << OFFSET_BITS) | longint'(offset));
            t.hit_total   = hit_count;
            t.fault_total = fault_count;
            awaited.push_back(t);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(phys_t pa, logic hit, logic fault, count_t ht, count_t ft);
            translation_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result %0d arrived with nothing outstanding: pa=%h",
                               results_seen, pa));
                return;
            end
            want = awaited.pop_front();
            if (pa !== want.phys || hit !== want.hit || fault !== want.fault ||
                ht !== want.hit_total || ft !== want.fault_total)
                flag($sformatf({"result %0d: expected pa=%h hit=%b fault=%b hits=%0d faults=%0d,",
                                " got pa=%h hit=%b fault=%b hits=%0d faults=%0d"},
                               results_seen, want.phys, want.hit, want.fault, want.hit_total,
                               want.fault_total, pa, hit, fault, ht, ft));
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    addr_t  vaddr = '0;
    logic   out_valid;
    logic   out_stall = 1'b1;
    phys_t  paddr;
    logic   tlb_hit;
    logic   page_fault;
    count_t hit_total;
    count_t fault_total;

    translation_scoreboard sb;
    int    gap_pct = 0;
    int    stall_pct = 0;
    bit    hold_off_req = 1'b0;
    int    sent = 0;
    page_t fresh_cursor = 8'h10;
    page_t recent[$];

    tlb_page_translator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vaddr       (vaddr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .paddr       (paddr),
        .tlb_hit     (tlb_hit),
        .page_fault  (page_fault),
        .hit_total   (hit_total),
        .fault_total (fault_total)
    );

    always #6 clk = ~clk;

    // one stall decision per burst; a hold-off request overrides the burst length
    always
    begin : receiver
        int span;
        span = $urandom_range(1, 9);
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            span = HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
        repeat (span) @(posedge clk);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(paddr, tlb_hit, page_fault, hit_total, fault_total);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles without a beat", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_address(input addr_t addr);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            vaddr <= addr_t'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        vaddr <= addr;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_address(addr);
        sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic page_t next_fresh_page();
        while (sb.page_mapped(fresh_cursor))
            fresh_cursor++;
        fresh_cursor++;
        return fresh_cursor - 1'b1;
    endfunction

    // working-set traffic: mostly recent pages, some warm ones, some brand new, some random
    function automatic addr_t mix_address();
        int    r;
        page_t p;
        r = $urandom_range(0, 99);
        if (r >= 88)
            return addr_t'($urandom);
        if (r < 50 && recent.size() != 0)
            p = recent[$urandom_range(0, recent.size() - 1)];
        else if (r < 72)
            p = page_t'(WARM_BASE + $urandom_range(0, WARM_PAGES - 1));
        else
            p = next_fresh_page();
        recent.push_back(p);
        if (recent.size() > 12)
            void'(recent.pop_front());
        return {p, offset_t'($urandom)};
    endfunction

    initial
    begin : stimulus
        int    k;
        page_t p;
        bit    live;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'hA55A);
        send_address(16'h5AA5);
        // pages 1..16 push the fill slot round, evicting the first entries
        for (k = 1; k <= 16; k++)
            send_address({page_t'(k), offset_t'($urandom)});
        send_address(16'h0080);
        send_address(16'hFF7F);

        // fill the frame table and wrap into reuse
        for (k = 0; k < 140; k++)
            send_address({next_fresh_page(), offset_t'($urandom)});

        // pull the next victim into the TLB, recycle its frame, then touch it again
        for (k = 0; k < 30; k++)
        begin
            live = sb.victim(p);
            if (live)
                send_address({p, offset_t'($urandom)});
            send_address({next_fresh_page(), offset_t'($urandom)});
            if (live)
                send_address({p, offset_t'($urandom)});
        end

        for (k = 0; k < MIX_ITEMS; k++)
        begin
            if (k % 50 == 0)
            begin
                gap_pct   = (k % 150 == 100) ? 0 : 40 * $urandom_range(0, 1) + 15;
                stall_pct = (k % 150 == 100) ? 0 : 40 * $urandom_range(0, 1) + 15;
            end
            if (k == 150)
                hold_off_req = 1'b1;
            if (k == 400)
                wait_for_results();
            send_address(mix_address());
        end

        gap_pct   = 0;
        stall_pct = 0;
        for (k = 0; k < TAIL_ITEMS; k++)
            send_address(mix_address());

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d addresses translated, %0d results checked: %0d TLB hits, %0d page faults",
                 sent, sb.results_seen, sb.hit_count, sb.fault_count);
        $display("%0d frames recycled, %0d TLB entries dropped on recycle; %s",
                 sb.reuses, sb.invalidations, "hold-off and drain done");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_ram.sv
rtl/core/tlb_page_translator.sv
bench/testbench.sv
